// ===== hw/rtl/greedy_neighbour_deferral_assert.svh =====
// Assertion macros for the neighbour deferral block
`ifndef GREEDY_NEIGHBOUR_DEFERRAL_ASSERT_SVH
`define GREEDY_NEIGHBOUR_DEFERRAL_ASSERT_SVH
`ifndef SYNTHESIS
`define GND_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define GND_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define GND_ASSERT_IMP(label, clk, rstn, ante, cons)
`define GND_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif
`endif

// ===== hw/rtl/gnd_pkg.sv =====
// ---------------------------------------------------------------------------
// gnd_pkg
// Shared types and constants of the neighbour deferral block.
// ---------------------------------------------------------------------------
package gnd_pkg;
    localparam int EDGE_DEPTH = 1024;
    localparam int LIST_DEPTH = 256;
    localparam int NODE_BITS  = 16;
    localparam int EA_BITS    = $clog2(EDGE_DEPTH);
    localparam int LA_BITS    = $clog2(LIST_DEPTH);
    localparam int ECNT_BITS  = EA_BITS + 1;
    localparam int LCNT_BITS  = LA_BITS + 1;
    // Deferrals in one run: a zero row can hit the same zero candidate once
    // per visited candidate, so the count can pass the list length
    localparam int RUN_CNT_BITS = 2 * LA_BITS;
    localparam int SLOT_BITS  = 10;
    localparam int CMD_BITS   = 2;
    localparam int ST_BITS    = 2;
    localparam int RATIO_BITS = 16;
    localparam int Q_DEPTH    = 2;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_LOAD_EDGE = 2'd0,
        CMD_LOAD_CAND = 2'd1,
        CMD_RUN       = 2'd2,
        CMD_READ      = 2'd3
    } cmd_t;

    typedef enum logic [ST_BITS-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    // Classified item from front to back
    typedef struct packed {
        cmd_t                 cmd;
        logic                 bad_slot;
        logic [SLOT_BITS-1:0] slot;
        logic [NODE_BITS-1:0] edge_row;
        logic [NODE_BITS-1:0] edge_col;
        logic [NODE_BITS-1:0] node_id;
    } op_t;

    typedef enum logic [3:0] {
        B_IDLE, B_READ, B_RDOUT, B_SKIPRD, B_SKIP, B_MRGRD, B_MERGE,
        B_NEXT, B_DIV, B_DONE
    } bstate_t;
endpackage

// ===== hw/rtl/gnd_front.sv =====
// ---------------------------------------------------------------------------
// gnd_front
// Accepts items, checks slot range and pushes them into a small queue.
// ---------------------------------------------------------------------------
module gnd_front
    import gnd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [CMD_BITS-1:0]  s_cmd,
    input  logic [SLOT_BITS-1:0] s_slot,
    input  logic [NODE_BITS-1:0] s_edge_row,
    input  logic [NODE_BITS-1:0] s_edge_col,
    input  logic [NODE_BITS-1:0] s_node_id,
    output logic                 q_valid,
    output op_t                  q_op,
    input  logic                 q_pop
);
    op_t  fifo_reg [Q_DEPTH];
    logic wptr_reg, rptr_reg, wptr_next, rptr_next;
    logic [1:0] cnt_reg, cnt_next;
    op_t  op_in;
    logic push;

    // Classify the incoming item
    always_comb begin
        op_in.cmd      = cmd_t'(s_cmd);
        op_in.slot     = s_slot;
        op_in.edge_row = s_edge_row;
        op_in.edge_col = s_edge_col;
        op_in.node_id  = s_node_id;
        if (cmd_t'(s_cmd) == CMD_LOAD_EDGE)
            op_in.bad_slot = ({1'b0, s_slot} >= (SLOT_BITS+1)'(EDGE_DEPTH));
        else if (cmd_t'(s_cmd) == CMD_RUN)
            op_in.bad_slot = 1'b0;
        else
            op_in.bad_slot = ({1'b0, s_slot} >= (SLOT_BITS+1)'(LIST_DEPTH));
    end

    assign s_ready = (cnt_reg != 2'(Q_DEPTH));
    assign push    = s_valid && s_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_op    = fifo_reg[rptr_reg];

    always_comb begin
        wptr_next = wptr_reg ^ push;
        rptr_next = rptr_reg ^ q_pop;
        cnt_next  = cnt_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) fifo_reg[wptr_reg] <= op_in;
    end
endmodule

// ===== hw/rtl/gnd_back.sv =====
// ---------------------------------------------------------------------------
// gnd_back
// Executes items: store loads, reads and the greedy merge walk, and holds
// the result register.
// ---------------------------------------------------------------------------
module gnd_back
    import gnd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [ECNT_BITS-1:0]  edge_total,
    input  logic [LCNT_BITS-1:0]  list_total,
    input  logic                  q_valid,
    input  op_t                   q_op,
    output logic                  q_pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [ST_BITS-1:0]    m_status,
    output logic [NODE_BITS-1:0]  m_list_entry,
    output logic [NODE_BITS-1:0]  m_deferred_entry,
    output logic [LCNT_BITS-1:0]  m_deferred_total,
    output logic [LCNT_BITS-1:0]  m_independent_total,
    output logic [RATIO_BITS-1:0] m_ratio_q16
);
`include "greedy_neighbour_deferral_assert.svh"

    localparam int DIV_BITS = LCNT_BITS + RATIO_BITS;

    logic [NODE_BITS-1:0] erow_mem [EDGE_DEPTH];
    logic [NODE_BITS-1:0] ecol_mem [EDGE_DEPTH];
    logic [NODE_BITS-1:0] cand_mem [LIST_DEPTH];
    logic [NODE_BITS-1:0] dfr_mem  [LIST_DEPTH];

    bstate_t state_reg, state_next;
    op_t     op_reg;
    logic [ECNT_BITS-1:0] e_reg, ne_reg;
    logic [LCNT_BITS-1:0] i_reg, k_reg, nl_reg;
    logic [RUN_CNT_BITS-1:0] cnt_reg;
    logic [NODE_BITS-1:0] cur_reg, erow_rd, ecol_rd, ci_rd, ck_rd, dfr_rd;
    logic [DIV_BITS-1:0]  rem_reg;
    logic [RATIO_BITS+LCNT_BITS-1:0] quo_reg;
    logic [4:0] dstep_reg;
    logic [LCNT_BITS-1:0] dcnt_reg, icnt_reg;
    logic [RATIO_BITS-1:0] ratio_reg;
    logic out_free;
    logic set_res;

    logic [EA_BITS-1:0] e_addr;
    logic [LA_BITS-1:0] ci_addr, ck_addr, c_waddr, d_waddr;
    logic [NODE_BITS-1:0] c_wdata, d_wdata;
    logic c_we, d_we, e_we;

    assign out_free = !m_valid || m_ready;

    // Memory addressing
    always_comb begin
        e_addr  = e_reg[EA_BITS-1:0];
        ci_addr = i_reg[LA_BITS-1:0];
        ck_addr = k_reg[LA_BITS-1:0];
        e_we    = (state_reg == B_IDLE) && q_valid && q_op.cmd == CMD_LOAD_EDGE
                  && !q_op.bad_slot && out_free;
        c_we    = 1'b0;
        c_waddr = q_op.slot[LA_BITS-1:0];
        c_wdata = q_op.node_id;
        d_we    = 1'b0;
        d_waddr = cnt_reg[LA_BITS-1:0];
        d_wdata = ck_rd;
        if (state_reg == B_IDLE) begin
            c_we = q_valid && q_op.cmd == CMD_LOAD_CAND && !q_op.bad_slot && out_free;
            if (q_op.cmd == CMD_READ) ci_addr = q_op.slot[LA_BITS-1:0];
        end else if (state_reg == B_READ) begin
            // hold the read slot in B_READ, once the item has left the queue
            ci_addr = op_reg.slot[LA_BITS-1:0];
        end else if (state_reg == B_MERGE && e_reg < ne_reg && k_reg < nl_reg
                     && ecol_rd == cur_reg && erow_rd == ck_rd) begin
            c_we    = 1'b1;
            c_waddr = k_reg[LA_BITS-1:0];
            c_wdata = '0;
            d_we    = (cnt_reg < RUN_CNT_BITS'(LIST_DEPTH));
        end
    end

    // Memories with registered reads
    always_ff @(posedge aclk) begin
        if (e_we) begin
            erow_mem[q_op.slot[EA_BITS-1:0]] <= q_op.edge_row;
            ecol_mem[q_op.slot[EA_BITS-1:0]] <= q_op.edge_col;
        end
        erow_rd <= erow_mem[e_addr];
        ecol_rd <= ecol_mem[e_addr];
    end
    always_ff @(posedge aclk) begin
        if (c_we) cand_mem[c_waddr] <= c_wdata;
        ci_rd <= cand_mem[ci_addr];
        ck_rd <= cand_mem[ck_addr];
    end
    always_ff @(posedge aclk) begin
        if (d_we) dfr_mem[d_waddr] <= d_wdata;
        dfr_rd <= dfr_mem[ci_addr];
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE: begin
                if (q_valid && out_free) begin
                    if (q_op.cmd == CMD_READ && !q_op.bad_slot) state_next = B_READ;
                    else if (q_op.cmd == CMD_RUN && list_total != '0) state_next = B_NEXT;
                end
            end
            B_READ:   state_next = B_RDOUT;
            B_RDOUT:  state_next = B_IDLE;
            B_NEXT:   state_next = (i_reg >= nl_reg) ? B_DIV : B_SKIPRD;
            B_SKIPRD: state_next = B_SKIP;
            B_SKIP: begin
                if (ci_rd == '0) state_next = B_NEXT;
                else if (e_reg < ne_reg && ecol_rd < ci_rd) state_next = B_SKIPRD;
                else state_next = B_MRGRD;
            end
            B_MRGRD: state_next = B_MERGE;
            B_MERGE: begin
                if (e_reg < ne_reg && k_reg < nl_reg && ecol_rd == cur_reg)
                    state_next = B_MRGRD;
                else
                    state_next = B_NEXT;
            end
            B_DIV:    state_next = (dstep_reg == 5'(RATIO_BITS + LCNT_BITS)) ? B_DONE : B_DIV;
            B_DONE:   state_next = out_free ? B_IDLE : B_DONE;
            default:  state_next = B_IDLE;
        endcase
    end

    assign q_pop = (state_reg == B_IDLE) && q_valid && out_free;

    // A result is loaded into the output register this cycle
    assign set_res = (q_pop && !((q_op.cmd == CMD_READ && !q_op.bad_slot) ||
                                 (q_op.cmd == CMD_RUN && list_total != '0)))
                     || (state_reg == B_RDOUT)
                     || (state_reg == B_DONE && out_free);

    // Datapath registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            B_IDLE: if (q_pop) begin
                op_reg <= q_op;
                ne_reg <= (edge_total > ECNT_BITS'(EDGE_DEPTH)) ? ECNT_BITS'(EDGE_DEPTH)
                                                                : edge_total;
                nl_reg <= (list_total > LCNT_BITS'(LIST_DEPTH)) ? LCNT_BITS'(LIST_DEPTH)
                                                                : list_total;
                e_reg  <= '0;
                i_reg  <= '0;
                cnt_reg <= '0;
            end
            B_NEXT: begin
                dstep_reg <= '0;
                quo_reg   <= '0;
                rem_reg   <= '0;
            end
            B_SKIP: begin
                cur_reg <= ci_rd;
                k_reg   <= i_reg + 1'b1;
                if (ci_rd == '0) i_reg <= i_reg + 1'b1;
                else if (e_reg < ne_reg && ecol_rd < ci_rd) e_reg <= e_reg + 1'b1;
            end
            B_MERGE: begin
                if (e_reg < ne_reg && k_reg < nl_reg && ecol_rd == cur_reg) begin
                    if (erow_rd < ck_rd) e_reg <= e_reg + 1'b1;
                    else if (erow_rd > ck_rd) k_reg <= k_reg + 1'b1;
                    else begin
                        e_reg <= e_reg + 1'b1;
                        k_reg <= k_reg + 1'b1;
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end else begin
                    i_reg <= i_reg + 1'b1;
                end
            end
            B_DIV: if (dstep_reg != 5'(RATIO_BITS + LCNT_BITS)) begin
                // Restoring division, one quotient bit per cycle; a count above
                // the list length saturates anyway, so its low bits suffice
                logic [DIV_BITS-1:0] num, tr;
                num = {cnt_reg[LCNT_BITS-1:0], {RATIO_BITS{1'b0}}};
                tr  = {rem_reg[DIV_BITS-2:0], num[DIV_BITS-1-dstep_reg]};
                if (tr >= DIV_BITS'(nl_reg)) begin
                    rem_reg <= tr - DIV_BITS'(nl_reg);
                    quo_reg <= {quo_reg[DIV_BITS-2:0], 1'b1};
                end else begin
                    rem_reg <= tr;
                    quo_reg <= {quo_reg[DIV_BITS-2:0], 1'b0};
                end
                dstep_reg <= dstep_reg + 1'b1;
            end
            default: ;
        endcase
    end

    // Result counters and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
            m_valid   <= 1'b0;
            dcnt_reg  <= '0;
            icnt_reg  <= '0;
            ratio_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (set_res) m_valid <= 1'b1;
            else if (m_ready) m_valid <= 1'b0;
            if (q_pop) begin
                if (!((q_op.cmd == CMD_READ && !q_op.bad_slot) ||
                      (q_op.cmd == CMD_RUN && list_total != '0))) begin
                    m_list_entry <= '0;
                    m_deferred_entry <= '0;
                    m_status <= q_op.bad_slot ? ST_RANGE :
                                (q_op.cmd == CMD_RUN) ? ST_EMPTY : ST_OK;
                    m_deferred_total    <= dcnt_reg;
                    m_independent_total <= icnt_reg;
                    m_ratio_q16         <= ratio_reg;
                end
            end
            if (state_reg == B_RDOUT) begin
                m_status <= ST_OK;
                m_list_entry <= ci_rd;
                m_deferred_entry <= dfr_rd;
                m_deferred_total    <= dcnt_reg;
                m_independent_total <= icnt_reg;
                m_ratio_q16         <= ratio_reg;
            end
            if (state_reg == B_DONE && out_free) begin
                logic [RATIO_BITS-1:0] r;
                r = ((cnt_reg > RUN_CNT_BITS'(nl_reg)) ||
                     (quo_reg[DIV_BITS-1:RATIO_BITS] != '0)) ? '1 : quo_reg[RATIO_BITS-1:0];
                dcnt_reg  <= cnt_reg[LCNT_BITS-1:0];
                icnt_reg  <= nl_reg - cnt_reg[LCNT_BITS-1:0];
                ratio_reg <= r;
                m_status <= ST_OK;
                m_list_entry <= '0;
                m_deferred_entry <= '0;
                m_deferred_total    <= cnt_reg[LCNT_BITS-1:0];
                m_independent_total <= nl_reg - cnt_reg[LCNT_BITS-1:0];
                m_ratio_q16         <= r;
            end
        end
    end

    `GND_ASSERT_IMP(a_pop_idle, aclk, aresetn, q_pop, state_reg == B_IDLE && out_free)
    `GND_ASSERT_NXT(a_rd_out, aclk, aresetn, state_reg == B_RDOUT, m_valid)
    `GND_ASSERT_IMP(a_nl_range, aclk, aresetn, state_reg == B_DONE, (nl_reg != '0) && (nl_reg <= LCNT_BITS'(LIST_DEPTH)))
endmodule

// ===== hw/rtl/greedy_neighbour_deferral.sv =====
// ---------------------------------------------------------------------------
// greedy_neighbour_deferral
// Greedy independent-set selection over a sorted adjacency list.
// ---------------------------------------------------------------------------
// Load items retire straight from B_IDLE and read items pass through B_READ
// and B_RDOUT; a run item walks the candidate list and edge list: B_NEXT,
// B_SKIPRD and B_SKIP per visited candidate, B_SKIPRD and B_SKIP per edge
// skipped ahead and B_MRGRD and B_MERGE per merge step, then a serial divider
// in B_DIV for the ratio and B_DONE to hand out the result. Each step waits
// for a registered memory read. No clearing pass is needed after reset.
module greedy_neighbour_deferral
    import gnd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [ECNT_BITS-1:0]  cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [CMD_BITS-1:0]   s_cmd,
    input  logic [SLOT_BITS-1:0]  s_slot,
    input  logic [NODE_BITS-1:0]  s_edge_row,
    input  logic [NODE_BITS-1:0]  s_edge_col,
    input  logic [NODE_BITS-1:0]  s_node_id,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [ST_BITS-1:0]    m_status,
    output logic [NODE_BITS-1:0]  m_list_entry,
    output logic [NODE_BITS-1:0]  m_deferred_entry,
    output logic [LCNT_BITS-1:0]  m_deferred_total,
    output logic [LCNT_BITS-1:0]  m_independent_total,
    output logic [RATIO_BITS-1:0] m_ratio_q16
);
    logic [ECNT_BITS-1:0] edge_total_reg;
    logic [LCNT_BITS-1:0] list_total_reg;
    logic q_valid, q_pop;
    op_t  q_op;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            edge_total_reg <= '0;
            list_total_reg <= '0;
        end else if (cfg_we) begin
            if (cfg_index == 1'b0) edge_total_reg <= cfg_data;
            else list_total_reg <= cfg_data[LCNT_BITS-1:0];
        end
    end

    gnd_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_cmd, .s_slot, .s_edge_row,
        .s_edge_col, .s_node_id, .q_valid, .q_op, .q_pop
    );

    gnd_back u_back (
        .aclk, .aresetn, .edge_total(edge_total_reg), .list_total(list_total_reg),
        .q_valid, .q_op, .q_pop, .m_valid, .m_ready, .m_status, .m_list_entry,
        .m_deferred_entry, .m_deferred_total, .m_independent_total, .m_ratio_q16
    );
endmodule

// ===== tb/gnd_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// gnd_checker
// Watches both channels, models the deferral walk and compares every result.
// ---------------------------------------------------------------------------
module gnd_checker
    import gnd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [ECNT_BITS-1:0]  cfg_data,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic [CMD_BITS-1:0]   s_cmd,
    input  logic [SLOT_BITS-1:0]  s_slot,
    input  logic [NODE_BITS-1:0]  s_edge_row,
    input  logic [NODE_BITS-1:0]  s_edge_col,
    input  logic [NODE_BITS-1:0]  s_node_id,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic [ST_BITS-1:0]    m_status,
    input  logic [NODE_BITS-1:0]  m_list_entry,
    input  logic [NODE_BITS-1:0]  m_deferred_entry,
    input  logic [LCNT_BITS-1:0]  m_deferred_total,
    input  logic [LCNT_BITS-1:0]  m_independent_total,
    input  logic [RATIO_BITS-1:0] m_ratio_q16,
    output int                    fail_count,
    output int                    pending_count,
    output int                    result_count,
    output int                    run_count,
    output int unsigned           defer_high
);

    typedef struct packed {
        logic [ST_BITS-1:0]    status;
        logic [NODE_BITS-1:0]  list_entry;
        logic [NODE_BITS-1:0]  deferred_entry;
        logic [LCNT_BITS-1:0]  deferred_total;
        logic [LCNT_BITS-1:0]  independent_total;
        logic [RATIO_BITS-1:0] ratio;
    } answer_t;

    logic [NODE_BITS-1:0]  row_mem [EDGE_DEPTH];
    logic [NODE_BITS-1:0]  col_mem [EDGE_DEPTH];
    logic [NODE_BITS-1:0]  cand_mem [LIST_DEPTH];
    logic [NODE_BITS-1:0]  defer_mem [LIST_DEPTH];
    logic [LCNT_BITS-1:0]  defer_cnt, indep_cnt;
    logic [RATIO_BITS-1:0] ratio_val;
    int unsigned           edges_used, list_used;
    answer_t               answers[$];

    // Greedy walk: defer later neighbours of every surviving candidate
    task automatic select_independent(input int unsigned ne, input int unsigned nl);
        int unsigned found, e, k;
        logic [NODE_BITS-1:0] cur, r, c;
        longint unsigned q;
        found = 0;
        e = 0;
        for (int unsigned i = 0; i < nl; i++) begin
            cur = cand_mem[i];
            if (cur == 0) continue;
            while (e < ne && col_mem[e] < cur) e++;
            k = i + 1;
            while (e < ne && k < nl && col_mem[e] == cur) begin
                r = row_mem[e];
                c = cand_mem[k];
                if (r < c) e++;
                else if (r > c) k++;
                else begin
                    if (found < LIST_DEPTH) defer_mem[found] = c;
                    cand_mem[k] = '0;
                    found++;
                    e++;
                    k++;
                end
            end
        end
        // deferred slots below this mark have been written at least once
        if (found > defer_high) defer_high = (found > LIST_DEPTH) ? LIST_DEPTH : found;
        q = (longint'(found) << 16) / nl;
        if (q > 65535) q = 65535;
        ratio_val = q[RATIO_BITS-1:0];
        defer_cnt = found[LCNT_BITS-1:0];
        indep_cnt = LCNT_BITS'(nl - found);
    endtask

    // Work out the answer for one accepted item
    task automatic predict_item(input cmd_t cmd, input logic [SLOT_BITS-1:0] slot,
                                input logic [NODE_BITS-1:0] er,
                                input logic [NODE_BITS-1:0] ec,
                                input logic [NODE_BITS-1:0] nid);
        answer_t a;
        int unsigned ne, nl;
        a = '0;
        a.status = ST_OK;
        case (cmd)
            CMD_LOAD_EDGE: begin
                row_mem[slot] = er;
                col_mem[slot] = ec;
            end
            CMD_LOAD_CAND: begin
                if (slot < LIST_DEPTH) cand_mem[slot] = nid;
                else a.status = ST_RANGE;
            end
            CMD_RUN: begin
                ne = edges_used > EDGE_DEPTH ? EDGE_DEPTH : edges_used;
                nl = list_used > LIST_DEPTH ? LIST_DEPTH : list_used;
                if (nl == 0) a.status = ST_EMPTY;
                else select_independent(ne, nl);
            end
            default: begin
                if (slot < LIST_DEPTH) begin
                    a.list_entry = cand_mem[slot];
                    a.deferred_entry = defer_mem[slot];
                end else a.status = ST_RANGE;
            end
        endcase
        a.deferred_total = defer_cnt;
        a.independent_total = indep_cnt;
        a.ratio = ratio_val;
        answers.push_back(a);
    endtask

    assign pending_count = answers.size();

    always @(posedge aclk) begin
        answer_t want, got;
        if (!aresetn) begin
            defer_cnt = '0;
            indep_cnt = '0;
            ratio_val = '0;
            edges_used = 0;
            list_used = 0;
            defer_high = 0;
            fail_count = 0;
            result_count = 0;
            run_count = 0;
            answers.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_index) list_used = cfg_data & 9'h1FF;
                else edges_used = cfg_data;
            end
            // Compare the result first: it cannot depend on an item taken now
            if (m_valid && m_ready) begin
                result_count++;
                got = {m_status, m_list_entry, m_deferred_entry, m_deferred_total,
                       m_independent_total, m_ratio_q16};
                if (answers.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) $display("unexpected result %h", got);
                end else begin
                    want = answers.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: st %0d/%0d le %h/%h de %h/%h dt %0d/%0d it %0d/%0d r %h/%h",
                                     want.status, got.status, want.list_entry,
                                     got.list_entry, want.deferred_entry,
                                     got.deferred_entry, want.deferred_total,
                                     got.deferred_total, want.independent_total,
                                     got.independent_total, want.ratio, got.ratio);
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (cmd_t'(s_cmd) == CMD_RUN) run_count++;
                predict_item(cmd_t'(s_cmd), s_slot, s_edge_row, s_edge_col, s_node_id);
            end
        end
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Drives loads, runs and reads into the deferral block and gives the verdict.
// ---------------------------------------------------------------------------
// Each phase loads a small sorted graph and candidate list, sets the counts,
// runs the selection and reads back. The checker predicts every result.
module tb_top;
    import gnd_pkg::*;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic                  cfg_index = 1'b0;
    logic [ECNT_BITS-1:0]  cfg_data = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [CMD_BITS-1:0]   s_cmd = '0;
    logic [SLOT_BITS-1:0]  s_slot = '0;
    logic [NODE_BITS-1:0]  s_edge_row = '0;
    logic [NODE_BITS-1:0]  s_edge_col = '0;
    logic [NODE_BITS-1:0]  s_node_id = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [ST_BITS-1:0]    m_status;
    logic [NODE_BITS-1:0]  m_list_entry, m_deferred_entry;
    logic [LCNT_BITS-1:0]  m_deferred_total, m_independent_total;
    logic [RATIO_BITS-1:0] m_ratio_q16;
    int                    fail_count, pending_count, result_count, run_count;
    int unsigned           defer_high;
    int                    send_idle = 30, recv_idle = 47;
    bit                    hold_off = 1'b0;
    int                    item_count = 0;
    logic [NODE_BITS-1:0]  node_list [LIST_DEPTH];

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    greedy_neighbour_deferral u_top (.*);

    gnd_checker u_check (.*);

    // Receiver: random stalls, plus a long hold-off when asked
    always @(negedge aclk) begin
        m_ready <= !hold_off && ($urandom_range(99) >= recv_idle);
    end

    // In-range read slots whose deferred entry was never written turn into
    // out-of-range reads
    function automatic int unsigned read_slot(input int unsigned slot);
        if (slot < LIST_DEPTH && slot >= defer_high) return slot + LIST_DEPTH;
        return slot;
    endfunction

    // Offer one item; valid stays up until accepted
    task automatic send_item(input cmd_t cmd, input int unsigned slot,
                             input int unsigned er, input int unsigned ec,
                             input int unsigned nid);
        while (send_idle > 0 && $urandom_range(99) < send_idle) @(negedge aclk);
        s_valid = 1'b1;
        s_cmd <= cmd;
        s_slot <= slot;
        s_edge_row <= er;
        s_edge_col <= ec;
        s_node_id <= nid;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        item_count++;
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    // Drain all results, then allow the block to settle before a config write
    task automatic drain_then_config(input int unsigned edges, input int unsigned cands);
        while (pending_count != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= 1'b0;
        cfg_data <= edges;
        @(negedge aclk);
        cfg_index <= 1'b1;
        cfg_data <= cands;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Build a sorted graph over a sorted candidate list and run it
    task automatic random_phase(input int unsigned nl, input int unsigned ne_max,
                                input bit noisy);
        int unsigned ne, node, col_i;
        int unsigned rows [$];
        node = $urandom_range(3);
        for (int unsigned i = 0; i < nl; i++) begin
            node += $urandom_range(1, 3);
            node_list[i] = (noisy && $urandom_range(9) == 0) ? 0 : node;
            send_item(CMD_LOAD_CAND, i, $urandom, $urandom, node_list[i]);
        end
        ne = 0;
        col_i = 0;
        while (ne < ne_max && col_i < nl) begin
            // rows for this column, ascending
            rows.delete();
            for (int unsigned r = col_i + 1; r < nl && ne + rows.size() < ne_max; r++)
                if ($urandom_range(2) == 0) rows.push_back(node_list[r]);
            foreach (rows[j]) begin
                send_item(CMD_LOAD_EDGE, ne, noisy && $urandom_range(7) == 0 ?
                          $urandom : rows[j], node_list[col_i], 0);
                ne++;
            end
            col_i += $urandom_range(1, 2);
        end
        drain_then_config(ne, nl);
        send_item(CMD_RUN, $urandom, $urandom, $urandom, $urandom);
        for (int unsigned i = 0; i < nl + 2; i++)
            send_item(CMD_READ, read_slot($urandom_range(3) == 0 ? $urandom_range(1023) :
                      $urandom_range(nl - 1)), $urandom, $urandom, $urandom);
    endtask

    initial begin
        #900000000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: empty list run, extremes, range errors
        send_item(CMD_RUN, 0, 0, 0, 0);
        send_item(CMD_LOAD_CAND, 0, 16'hFFFF, 16'hFFFF, 16'h0001);
        send_item(CMD_LOAD_CAND, 1, 0, 0, 16'h0002);
        send_item(CMD_LOAD_CAND, 2, 0, 0, 16'hFFFF);
        send_item(CMD_LOAD_CAND, 3, 0, 0, 16'h0000);
        send_item(CMD_LOAD_CAND, 256, 0, 0, 16'h1234);
        send_item(CMD_LOAD_CAND, 1023, 0, 0, 16'hABCD);
        send_item(CMD_LOAD_EDGE, 0, 16'h0002, 16'h0001, 0);
        send_item(CMD_LOAD_EDGE, 1, 16'hFFFF, 16'h0001, 0);
        send_item(CMD_LOAD_EDGE, 2, 16'h0000, 16'h0002, 0);
        send_item(CMD_LOAD_EDGE, 1023, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        drain_then_config(3, 4);
        send_item(CMD_RUN, 1023, 0, 0, 0);
        for (int i = 0; i < 4; i++) send_item(CMD_READ, read_slot(i), 0, 0, 0);
        send_item(CMD_READ, 256, 0, 0, 0);
        send_item(CMD_READ, 1023, 0, 0, 0);
        // Register above depth is clamped
        for (int i = 4; i < 256; i++) send_item(CMD_LOAD_CAND, i, 0, 0, 0);
        drain_then_config(1024, 256);
        send_item(CMD_RUN, 0, 0, 0, 0);
        send_item(CMD_READ, read_slot(255), 0, 0, 0);
        drain_then_config(2047, 511);
        send_item(CMD_RUN, 0, 0, 0, 0);

        // Long receiver hold-off while the sender keeps offering
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(negedge aclk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 12; i++) send_item(CMD_READ, read_slot(i), 0, 0, 0);
        join

        // Random phases under three idling schemes
        for (int p = 0; p < 3; p++) begin
            if (p == 1) begin send_idle = 47; recv_idle = 30; end
            if (p == 2) begin send_idle = 0; recv_idle = 0; end
            for (int j = 0; j < 4; j++)
                random_phase($urandom_range(2, 16), $urandom_range(0, 40), j % 3 == 2);
        end

        while (pending_count != 0) @(negedge aclk);
        repeat (60) @(negedge aclk);
        $display("covered %0d items, %0d results, %0d selection runs",
                 item_count, result_count, run_count);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/gnd_pkg.sv
hw/rtl/gnd_front.sv
hw/rtl/gnd_back.sv
hw/rtl/greedy_neighbour_deferral.sv
tb/gnd_checker.sv
tb/tb_top.sv
